// ===== rtl/lmco_pkg.sv =====
// Shared widths and constants of the logistic map chaos oscillator.
package lmco_pkg;

   // Level, map rate and configuration formats (unsigned Q1.16, 65536 = 1.0)
   localparam int LEVEL_W = 17;
   localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd6554;
   localparam int CSR_W = 17;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_PARAM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VALUE = 1'b1;

   // Map rate 3 + p, at most 4.0 in Q.16
   localparam int RATE_W = 19;
   localparam logic [RATE_W-1:0] RATE_BASE = 19'd196608;

   // Phase (signed Q.24) and step formats
   localparam int PHASE_W = 27;
   localparam int STEP_W = 26;
   localparam int PHASE_X_W = 29;
   localparam logic signed [PHASE_W-1:0] PHASE_ONE = 27'sd16777216;
   localparam logic signed [STEP_W-1:0] STEP_ONE = 26'sd16777216;
   localparam logic signed [PHASE_X_W-1:0] PHASE_ONE_X = 29'sd16777216;
   localparam logic signed [PHASE_X_W-1:0] PHASE_MAX_X = 29'sd67108863;
   localparam logic signed [PHASE_X_W-1:0] PHASE_MIN_X = -29'sd67108864;

   // Digit-serial multiplier: 2-bit digits of the multiplier per cycle
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 31;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS = MUL_A_W / 2;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

   // Stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CHAN_W = 4;
   localparam int CHAN_SLOTS = 16;

endpackage

// ===== rtl/lmco_serial_mul.sv =====
// Radix-4 digit-serial unsigned multiplier, one 2-bit multiplier digit per cycle.
module lmco_serial_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lmco_pkg::MUL_A_W-1:0]      mul_a,
   input  logic [lmco_pkg::MUL_B_W-1:0]      mul_b,
   output logic                              done,
   output logic [lmco_pkg::MUL_P_W-1:0]      product
);

   logic [lmco_pkg::MUL_A_W-1:0]   a_ff, a_in;
   logic [lmco_pkg::MUL_B_W-1:0]   b_ff, b_in;
   logic [lmco_pkg::MUL_B_W-1:0]   hi_ff, hi_in;
   logic [lmco_pkg::MUL_A_W-1:0]   lo_ff, lo_in;
   logic [lmco_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lmco_pkg::MUL_B_W+1:0]   part;
   logic [lmco_pkg::MUL_B_W+1:0]   sum;

   // Partial product of the low digit and the running sum
   always_comb begin
      part = (a_ff[0] ? {2'b00, b_ff} : '0) + (a_ff[1] ? {1'b0, b_ff, 1'b0} : '0);
      sum  = {2'b00, hi_ff} + part;
   end

   // Load on start, then retire one digit per cycle into the low half
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mul_a;
         b_in    = mul_b;
         hi_in   = '0;
         lo_in   = '0;
         cnt_in  = lmco_pkg::MUL_CNT_W'(lmco_pkg::MUL_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {2'b00, a_ff[lmco_pkg::MUL_A_W-1:2]};
         hi_in  = sum[lmco_pkg::MUL_B_W+1:2];
         lo_in  = {sum[1:0], lo_ff[lmco_pkg::MUL_A_W-1:2]};
         cnt_in = cnt_ff - lmco_pkg::MUL_CNT_W'(1);
         if (cnt_ff == lmco_pkg::MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== rtl/logistic_map_chaos_oscillator.sv =====
// Top level of the multichannel logistic map chaos oscillator.
//
// Requests arrive on the req_ stream: req_tuser is the action (0 advance,
// 1 restart), req_tdata carries the channel and the signed Q.24 phase step.
// Each request gives exactly one result on the rsp_ stream: rsp_tdata is the
// signed Q1.15 sample 2y-1, rsp_tuser flags that the level was recomputed.
// The csr_ port writes the map parameter p and the restart level.
//
// One request is worked on at a time. A request without a phase wrap, and a
// restart, go from S_LOAD straight to S_DONE; a wrap runs the logistic map
// through the shared radix-4 serial multiplier twice, in S_MUL1 and S_MUL2,
// before S_DONE hands the result to the output register.
// The output register frees the input side: a new request is taken while a
// result still waits for rsp_tready. A request that finishes while the
// previous result is still stalled holds until that result is taken.
// Synchronous reset presets every channel's phase to 1.0 and level to 0.1,
// p to 1.0 and the restart level to 0.1; no result is pending after reset.
module logistic_map_chaos_oscillator #(
   parameter int CHANNELS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [3:0] channel, [29:4] step, [31:30] zero
   input  logic [lmco_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: [0] action
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: [15:0] sample
   output logic [lmco_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] updated
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_wr_en,
   input  logic [lmco_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lmco_pkg::CSR_W-1:0]           csr_wr_data
);

   localparam int DEPTH = (CHANNELS < lmco_pkg::CHAN_SLOTS) ? CHANNELS : lmco_pkg::CHAN_SLOTS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // Channel field folded onto the channel count
   function automatic logic [lmco_pkg::CHAN_SLOTS-1:0][IDX_W-1:0] build_map();
      logic [lmco_pkg::CHAN_SLOTS-1:0][IDX_W-1:0] m;
      int c;
      c = 0;
      for (int i = 0; i < lmco_pkg::CHAN_SLOTS; i++) begin
         m[i] = IDX_W'(c);
         c = c + 1;
         if (c == CHANNELS) begin
            c = 0;
         end
      end
      return m;
   endfunction

   localparam logic [lmco_pkg::CHAN_SLOTS-1:0][IDX_W-1:0] CHAN_MAP = build_map();

   function automatic logic [lmco_pkg::RSP_DATA_W-1:0] to_sample(
      input logic [lmco_pkg::LEVEL_W-1:0] y
   );
      logic [lmco_pkg::RSP_DATA_W-1:0] s;
      if (y[lmco_pkg::LEVEL_W-1]) begin
         s = 16'h7FFF;
      end else begin
         s = {~y[15], y[14:0]};
      end
      return s;
   endfunction

   logic [2:0]                                 state_ff, state_in;
   logic [lmco_pkg::LEVEL_W-1:0]               rate_ff;
   logic [lmco_pkg::LEVEL_W-1:0]               init_ff;
   logic signed [lmco_pkg::PHASE_W-1:0]        phase_ff [DEPTH];
   logic [lmco_pkg::LEVEL_W-1:0]               level_ff [DEPTH];
   logic                                       act_ff;
   logic [IDX_W-1:0]                           idx_ff;
   logic signed [lmco_pkg::STEP_W-1:0]         step_ff, step_in;
   logic                                       upd_ff;
   logic [lmco_pkg::RSP_DATA_W-1:0]            rsp_data_ff;
   logic                                       rsp_user_ff;
   logic                                       rsp_valid_ff;

   logic                                       req_fire;
   logic signed [lmco_pkg::STEP_W-1:0]         req_step;
   logic [lmco_pkg::CSR_W-1:0]                 csr_clamped;
   logic signed [lmco_pkg::PHASE_W-1:0]        ph;
   logic [lmco_pkg::LEVEL_W-1:0]               lvl;
   logic                                       step_neg;
   logic                                       wrap;
   logic signed [lmco_pkg::PHASE_X_W-1:0]      ph_x, step_x, ph_w, ph_sum;
   logic signed [lmco_pkg::PHASE_W-1:0]        ph_next;
   logic signed [lmco_pkg::PHASE_W-1:0]        ph_restart;
   logic                                       mul_start;
   logic                                       mul_done;
   logic [lmco_pkg::MUL_A_W-1:0]               mul_a;
   logic [lmco_pkg::MUL_B_W-1:0]               mul_b;
   logic [lmco_pkg::MUL_P_W-1:0]               product;
   logic [lmco_pkg::RATE_W-1:0]                rate_full;
   logic [lmco_pkg::RATE_W:0]                  lvl_round;
   logic [lmco_pkg::LEVEL_W-1:0]               lvl_new;
   logic                                       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Saturate the incoming step to plus or minus 1.0
   always_comb begin
      req_step = signed'(req_tdata[29:4]);
      if (req_step > lmco_pkg::STEP_ONE) begin
         step_in = lmco_pkg::STEP_ONE;
      end else if (req_step < -lmco_pkg::STEP_ONE) begin
         step_in = -lmco_pkg::STEP_ONE;
      end else begin
         step_in = req_step;
      end
   end

   // Clamp configuration writes to 1.0
   assign csr_clamped = (csr_wr_data > lmco_pkg::ONE_Q16) ? lmco_pkg::ONE_Q16 : csr_wr_data;

   // Phase wrap test and phase advance for the current channel
   always_comb begin
      ph       = phase_ff[idx_ff];
      lvl      = level_ff[idx_ff];
      step_neg = step_ff[lmco_pkg::STEP_W-1];
      ph_x     = lmco_pkg::PHASE_X_W'(ph);
      step_x   = lmco_pkg::PHASE_X_W'(step_ff);
      if (step_neg) begin
         wrap = (ph <= 0);
      end else begin
         wrap = (ph >= lmco_pkg::PHASE_ONE);
      end
      if (!wrap) begin
         ph_w = ph_x;
      end else if (step_neg) begin
         ph_w = ph_x + lmco_pkg::PHASE_ONE_X;
      end else begin
         ph_w = ph_x - lmco_pkg::PHASE_ONE_X;
      end
      ph_sum = ph_w + step_x;
      if (ph_sum > lmco_pkg::PHASE_MAX_X) begin
         ph_next = lmco_pkg::PHASE_MAX_X[lmco_pkg::PHASE_W-1:0];
      end else if (ph_sum < lmco_pkg::PHASE_MIN_X) begin
         ph_next = lmco_pkg::PHASE_MIN_X[lmco_pkg::PHASE_W-1:0];
      end else begin
         ph_next = ph_sum[lmco_pkg::PHASE_W-1:0];
      end
      ph_restart = step_neg ? '0 : lmco_pkg::PHASE_ONE;
   end

   // Feed the shared multiplier: y*(1-y) first, then (3+p) times that
   always_comb begin
      rate_full = lmco_pkg::RATE_BASE + lmco_pkg::RATE_W'(rate_ff);
      if (state_ff == S_LOAD) begin
         mul_a = lmco_pkg::MUL_A_W'(lvl);
         mul_b = lmco_pkg::MUL_B_W'(lmco_pkg::ONE_Q16 - lvl);
      end else begin
         mul_a = lmco_pkg::MUL_A_W'(rate_full);
         mul_b = product[lmco_pkg::MUL_B_W-1:0];
      end
      mul_start = ((state_ff == S_LOAD) && !act_ff && wrap)
               || ((state_ff == S_MUL1) && mul_done);
   end

   // Round half up, drop 32 fraction bits, clamp at 1.0
   always_comb begin
      lvl_round = {1'b0, product[lmco_pkg::MUL_P_W-1:32]}
                + (lmco_pkg::RATE_W+1)'(product[31]);
      if (lvl_round > (lmco_pkg::RATE_W+1)'(lmco_pkg::ONE_Q16)) begin
         lvl_new = lmco_pkg::ONE_Q16;
      end else begin
         lvl_new = lvl_round[lmco_pkg::LEVEL_W-1:0];
      end
   end

   lmco_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (product)
   );

   // Sequence one request through load, map and result hand-off
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!act_ff && wrap) begin
               state_in = S_MUL1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL1: begin
            if (mul_done) begin
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            if (mul_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Capture the request, and in S_LOAD whether the level is recomputed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req_tuser;
         idx_ff  <= CHAN_MAP[req_tdata[lmco_pkg::CHAN_W-1:0]];
         step_ff <= step_in;
      end
      if (state_ff == S_LOAD) begin
         upd_ff <= !act_ff && wrap;
      end
   end

   // Control state, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= lmco_pkg::ONE_Q16;
         init_ff      <= lmco_pkg::LEVEL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               lmco_pkg::CSR_RATE_PARAM: rate_ff <= csr_clamped;
               lmco_pkg::CSR_INIT_VALUE: init_ff <= csr_clamped;
               default: ;
            endcase
         end
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         rsp_data_ff <= to_sample(lvl);
         rsp_user_ff <= upd_ff;
      end
   end

   // Channel stores: preset on reset, updated by restart, advance and map
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            phase_ff[i] <= lmco_pkg::PHASE_ONE;
            level_ff[i] <= lmco_pkg::LEVEL_RESET;
         end
      end else begin
         if (state_ff == S_LOAD) begin
            if (act_ff) begin
               phase_ff[idx_ff] <= ph_restart;
               level_ff[idx_ff] <= init_ff;
            end else begin
               phase_ff[idx_ff] <= ph_next;
            end
         end
         if ((state_ff == S_MUL2) && mul_done) begin
            level_ff[idx_ff] <= lvl_new;
         end
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/lmco_checker.sv =====
// Port-level checker for the oscillator, bound to the top level.
module lmco_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [lmco_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready
);

   // After reset nothing is pending and a request can be taken
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pending result or busy after reset");

   // A stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // Requests are worked one at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in work");

   // A new result only comes from a request in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a request in work");

endmodule

bind logistic_map_chaos_oscillator lmco_checker u_lmco_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
